// ===== sv/gcrg_pkg.sv =====
// Shared types, codes and constants of the grid cell reservation guide.
`default_nettype none

package gcrg_pkg;

    // Field widths
    localparam int COORD_W    = 6;
    localparam int ID_FIELD_W = 4;
    localparam int DIR_W      = 3;
    localparam int STATUS_W   = 3;
    localparam int COUNT_W    = 7;
    localparam int VCOUNT_W   = 5;
    localparam int OFFSETS_W  = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 16;
    // Wide enough for any parameter bound (up to 1024 rows or columns, 256 vehicles)
    localparam int LIM_W      = 11;
    localparam int VLIM_W     = 9;
    // Largest coordinate span that the fields can name
    localparam int COORD_SPAN = 1 << COORD_W;
    localparam int ID_SPAN    = 1 << ID_FIELD_W;

    // Default parameter values
    localparam int DEF_MAX_ROWS     = 64;
    localparam int DEF_MAX_COLUMNS  = 64;
    localparam int DEF_MAX_VEHICLES = 16;

    // Register reset values
    localparam logic [COUNT_W-1:0]   RST_ROW_COUNT     = 7'd64;
    localparam logic [COUNT_W-1:0]   RST_COLUMN_COUNT  = 7'd64;
    localparam logic [VCOUNT_W-1:0]  RST_VEHICLE_COUNT = 5'd16;
    localparam logic [OFFSETS_W-1:0] RST_DIR_OFFSETS   = 16'd19475;

    // Register indexes
    localparam logic [CFG_IDX_W-1:0] CFG_ROW_COUNT     = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_COLUMN_COUNT  = 2'd1;
    localparam logic [CFG_IDX_W-1:0] CFG_VEHICLE_COUNT = 2'd2;
    localparam logic [CFG_IDX_W-1:0] CFG_DIR_OFFSETS   = 2'd3;

    // Request actions
    localparam logic ACT_PLACE = 1'b0;
    localparam logic ACT_STEP  = 1'b1;

    // Direction and status codes
    localparam logic [DIR_W-1:0] DIR_STOP = 3'd4;

    localparam logic [STATUS_W-1:0] ST_OK          = 3'd0;
    localparam logic [STATUS_W-1:0] ST_BAD_ID      = 3'd1;
    localparam logic [STATUS_W-1:0] ST_BAD_CURRENT = 3'd2;
    localparam logic [STATUS_W-1:0] ST_BAD_GOAL    = 3'd3;
    localparam logic [STATUS_W-1:0] ST_UNEXPECTED  = 3'd4;
    localparam logic [STATUS_W-1:0] ST_START_TAKEN = 3'd5;

    typedef struct packed {
        logic                  action;
        logic [ID_FIELD_W-1:0] vehicle_id;
        logic [COORD_W-1:0]    current_row;
        logic [COORD_W-1:0]    current_column;
        logic [COORD_W-1:0]    goal_row;
        logic [COORD_W-1:0]    goal_column;
    } t_in_item;

    typedef struct packed {
        logic [DIR_W-1:0]    step_direction;
        logic [STATUS_W-1:0] status_code;
    } t_out_item;

    typedef struct packed {
        logic [COORD_W-1:0] row;
        logic [COORD_W-1:0] col;
    } t_cell;

    // Neighbor unit result
    typedef struct packed {
        logic  in_grid;
        logic  toward;
        t_cell pos;
    } t_nbr_res;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CHK_CUR,
        S_CHK_GOAL,
        S_PLACE_RD,
        S_PLACE_EVAL,
        S_NBR_RD,
        S_NBR_EVAL,
        S_EXPECT,
        S_TGT_RD,
        S_TGT_EVAL,
        S_DONE
    } t_state;

endpackage

`default_nettype wire

// ===== sv/gcrg_nbr_unit.sv =====
// Shared neighbor unit: offset add, grid bounds compare and goal direction test.
`default_nettype none

module gcrg_nbr_unit #(
    parameter int MAX_ROWS    = gcrg_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS = gcrg_pkg::DEF_MAX_COLUMNS
) (
    input  gcrg_pkg::t_cell                    i_base,
    input  logic [3:0]                         i_offset,
    input  gcrg_pkg::t_cell                    i_goal,
    input  logic [gcrg_pkg::COUNT_W-1:0]       i_row_count,
    input  logic [gcrg_pkg::COUNT_W-1:0]       i_column_count,
    output gcrg_pkg::t_nbr_res                 o_res
);

    logic [7:0] w_off_row;
    logic [7:0] w_off_col;
    logic [7:0] w_row;
    logic [7:0] w_col;
    logic [7:0] w_drow;
    logic [7:0] w_dcol;
    logic [9:0] w_dot;
    logic       w_row_ok;
    logic       w_col_ok;

    // Offset times delta for a 2-bit signed offset
    function automatic logic [9:0] scale(input logic [1:0] off, input logic [7:0] d);
        logic [9:0] d10;
        logic [9:0] res;
        d10 = {{2{d[7]}}, d};
        case (off)
            2'b01:   res = d10;
            2'b10:   res = 10'(-(d10 << 1));
            2'b11:   res = 10'(-d10);
            default: res = '0;
        endcase
        return res;
    endfunction

    assign w_off_row = {{6{i_offset[1]}}, i_offset[1:0]};
    assign w_off_col = {{6{i_offset[3]}}, i_offset[3:2]};
    assign w_row     = {2'b00, i_base.row} + w_off_row;
    assign w_col     = {2'b00, i_base.col} + w_off_col;

    assign w_row_ok = !w_row[7] && (w_row[6:0] < i_row_count)
                      && ({4'b0000, w_row[6:0]} < gcrg_pkg::LIM_W'(MAX_ROWS));
    assign w_col_ok = !w_col[7] && (w_col[6:0] < i_column_count)
                      && ({4'b0000, w_col[6:0]} < gcrg_pkg::LIM_W'(MAX_COLUMNS));

    assign w_drow = {2'b00, i_goal.row} - {2'b00, i_base.row};
    assign w_dcol = {2'b00, i_goal.col} - {2'b00, i_base.col};
    assign w_dot  = scale(i_offset[1:0], w_drow) + scale(i_offset[3:2], w_dcol);

    assign o_res.in_grid = w_row_ok && w_col_ok;
    assign o_res.toward  = !w_dot[9] && (w_dot != '0);
    assign o_res.pos.row = w_row[5:0];
    assign o_res.pos.col = w_col[5:0];

endmodule

`default_nettype wire

// ===== sv/gcrg_cell_map.sv =====
// Cell ownership memory with a clearing sweep after reset.
`default_nettype none

module gcrg_cell_map #(
    parameter int ADDR_W       = 12,
    parameter int MAX_VEHICLES = gcrg_pkg::DEF_MAX_VEHICLES
) (
    input  logic                                   i_clk,
    input  logic                                   i_rst_n,
    input  logic                                   i_wr_en,
    input  logic [ADDR_W-1:0]                      i_wr_addr,
    input  logic [$clog2(MAX_VEHICLES+1)-1:0]      i_wr_data,
    input  logic                                   i_rd_en,
    input  logic [ADDR_W-1:0]                      i_rd_addr,
    output logic [$clog2(MAX_VEHICLES+1)-1:0]      o_rd_data,
    output logic                                   o_busy
);

    localparam int DATA_W = $clog2(MAX_VEHICLES + 1);
    localparam int DEPTH  = 1 << ADDR_W;
    localparam logic [DATA_W-1:0] FREE_MARK = DATA_W'(MAX_VEHICLES);

    logic [DATA_W-1:0] r_mem [DEPTH];
    logic [DATA_W-1:0] r_rd_data;
    logic              r_clr_busy;
    logic [ADDR_W-1:0] r_clr_addr;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            r_clr_addr <= r_clr_addr + ADDR_W'(1);
            if (&r_clr_addr) begin
                r_clr_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= FREE_MARK;
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rd_en) begin
            r_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_rd_data = r_rd_data;
    assign o_busy    = r_clr_busy;

endmodule

`default_nettype wire

// ===== sv/grid_cell_reservation_guide_core.sv =====
// Top level of the grid cell reservation guide: sequencer, registers and vehicle tables.
//
//  channel   | signals                            | direction | carries
//  ----------+------------------------------------+-----------+---------------------------
//  request   | i_in_valid, o_in_stall, i_in_data  | in        | place or step request
//  result    | o_out_valid, i_out_stall, o_out_data| out      | direction and status
//  config    | i_cfg_we, i_cfg_index, i_cfg_data  | in        | register write
//
// A step request checks its current cell and goal, reads and evaluates four neighbors,
// checks the expected cell and reads and evaluates the target; a place request checks,
// reads and evaluates its start cell; a rejected one ends at its failing check (bad id
// or current cell, bad goal, start taken or unexpected current cell); the shared
// neighbor unit and the one read port of the ownership memory are visited once per
// neighbor, read then evaluate. After reset the ownership memory is swept clear, one
// cell per cycle; requests are stalled then. A result waits in its output register
// while the next request is taken; a finished request holds until that register is free.
`default_nettype none

module grid_cell_reservation_guide_core #(
    parameter int MAX_ROWS     = gcrg_pkg::DEF_MAX_ROWS,
    parameter int MAX_COLUMNS  = gcrg_pkg::DEF_MAX_COLUMNS,
    parameter int MAX_VEHICLES = gcrg_pkg::DEF_MAX_VEHICLES
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_in_valid,
    output logic                                  o_in_stall,
    input  gcrg_pkg::t_in_item                    i_in_data,
    output logic                                  o_out_valid,
    input  logic                                  i_out_stall,
    output gcrg_pkg::t_out_item                   o_out_data,
    input  logic                                  i_cfg_we,
    input  logic [gcrg_pkg::CFG_IDX_W-1:0]        i_cfg_index,
    input  logic [gcrg_pkg::CFG_DATA_W-1:0]       i_cfg_data
);

    localparam int ROW_SPAN = (MAX_ROWS < gcrg_pkg::COORD_SPAN) ? MAX_ROWS
                              : gcrg_pkg::COORD_SPAN;
    localparam int COL_SPAN = (MAX_COLUMNS < gcrg_pkg::COORD_SPAN) ? MAX_COLUMNS
                              : gcrg_pkg::COORD_SPAN;
    localparam int VEH_SPAN = (MAX_VEHICLES < gcrg_pkg::ID_SPAN) ? MAX_VEHICLES
                              : gcrg_pkg::ID_SPAN;
    localparam int ROW_W    = (ROW_SPAN > 1) ? $clog2(ROW_SPAN) : 1;
    localparam int COL_W    = (COL_SPAN > 1) ? $clog2(COL_SPAN) : 1;
    localparam int ID_W     = (VEH_SPAN > 1) ? $clog2(VEH_SPAN) : 1;
    localparam int ADDR_W   = ROW_W + COL_W;
    localparam int OWN_W    = $clog2(MAX_VEHICLES + 1);
    localparam logic [OWN_W-1:0] FREE_MARK = OWN_W'(MAX_VEHICLES);

    function automatic logic [ADDR_W-1:0] cell_addr(input gcrg_pkg::t_cell c);
        return {c.row[ROW_W-1:0], c.col[COL_W-1:0]};
    endfunction

    gcrg_pkg::t_state    r_state, n_state;
    gcrg_pkg::t_in_item  r_req;
    logic [1:0]          r_k, n_k;
    logic [gcrg_pkg::DIR_W-1:0]    r_dir, n_dir;
    logic [gcrg_pkg::STATUS_W-1:0] r_status, n_status;
    gcrg_pkg::t_cell     r_next, n_next;
    logic                r_out_valid, n_out_valid;
    gcrg_pkg::t_out_item r_out, n_out;

    logic [gcrg_pkg::COUNT_W-1:0]   r_row_count;
    logic [gcrg_pkg::COUNT_W-1:0]   r_column_count;
    logic [gcrg_pkg::VCOUNT_W-1:0]  r_vehicle_count;
    logic [gcrg_pkg::OFFSETS_W-1:0] r_dir_offsets;

    gcrg_pkg::t_cell r_prev [VEH_SPAN];
    gcrg_pkg::t_cell r_exp  [VEH_SPAN];

    logic              w_map_busy;
    logic              w_wr_en;
    logic [ADDR_W-1:0] w_wr_addr;
    logic [OWN_W-1:0]  w_wr_data;
    logic              w_rd_en;
    logic [ADDR_W-1:0] w_rd_addr;
    logic [OWN_W-1:0]  w_rd_data;

    logic              w_veh_we;
    gcrg_pkg::t_cell   w_veh_prev;
    gcrg_pkg::t_cell   w_veh_exp;

    gcrg_pkg::t_cell    w_base;
    logic [3:0]         w_nib;
    gcrg_pkg::t_nbr_res w_nbr;

    gcrg_pkg::t_cell  w_cur;
    gcrg_pkg::t_cell  w_goal;
    gcrg_pkg::t_cell  w_target;
    logic [ID_W-1:0]  w_id_idx;
    logic [OWN_W-1:0] w_id_own;
    logic             w_id_bad;
    logic             w_owner_ok;
    logic             w_in_fire;
    logic             w_out_fire;
    logic             w_out_free;

    assign w_cur.row  = r_req.current_row;
    assign w_cur.col  = r_req.current_column;
    assign w_goal.row = r_req.goal_row;
    assign w_goal.col = r_req.goal_column;
    assign w_id_idx   = r_req.vehicle_id[ID_W-1:0];
    assign w_id_own   = OWN_W'(r_req.vehicle_id);
    assign w_id_bad   = ({1'b0, r_req.vehicle_id} >= r_vehicle_count)
                        || ({5'b00000, r_req.vehicle_id} >= gcrg_pkg::VLIM_W'(MAX_VEHICLES));
    assign w_owner_ok = (w_rd_data == FREE_MARK) || (w_rd_data == w_id_own);
    assign w_target   = (w_rd_data != FREE_MARK) ? w_cur : r_next;

    assign o_in_stall  = (r_state != gcrg_pkg::S_IDLE) || w_map_busy;
    assign w_in_fire   = i_in_valid && !o_in_stall;
    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign w_out_fire  = r_out_valid && !i_out_stall;
    assign w_out_free  = !r_out_valid || !i_out_stall;

    gcrg_nbr_unit #(
        .MAX_ROWS    (MAX_ROWS),
        .MAX_COLUMNS (MAX_COLUMNS)
    ) u_nbr (
        .i_base         (w_base),
        .i_offset       (w_nib),
        .i_goal         (w_goal),
        .i_row_count    (r_row_count),
        .i_column_count (r_column_count),
        .o_res          (w_nbr)
    );

    gcrg_cell_map #(
        .ADDR_W       (ADDR_W),
        .MAX_VEHICLES (MAX_VEHICLES)
    ) u_map (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_wr_en   (w_wr_en),
        .i_wr_addr (w_wr_addr),
        .i_wr_data (w_wr_data),
        .i_rd_en   (w_rd_en),
        .i_rd_addr (w_rd_addr),
        .o_rd_data (w_rd_data),
        .o_busy    (w_map_busy)
    );

    // Next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            gcrg_pkg::S_IDLE: begin
                if (w_in_fire) begin
                    n_state = gcrg_pkg::S_CHK_CUR;
                end
            end
            gcrg_pkg::S_CHK_CUR: begin
                if (w_id_bad || !w_nbr.in_grid) begin
                    n_state = gcrg_pkg::S_DONE;
                end else if (r_req.action == gcrg_pkg::ACT_PLACE) begin
                    n_state = gcrg_pkg::S_PLACE_RD;
                end else begin
                    n_state = gcrg_pkg::S_CHK_GOAL;
                end
            end
            gcrg_pkg::S_PLACE_RD:   n_state = gcrg_pkg::S_PLACE_EVAL;
            gcrg_pkg::S_PLACE_EVAL: n_state = gcrg_pkg::S_DONE;
            gcrg_pkg::S_CHK_GOAL: begin
                n_state = w_nbr.in_grid ? gcrg_pkg::S_NBR_RD : gcrg_pkg::S_DONE;
            end
            gcrg_pkg::S_NBR_RD:   n_state = gcrg_pkg::S_NBR_EVAL;
            gcrg_pkg::S_NBR_EVAL: begin
                n_state = (&r_k) ? gcrg_pkg::S_EXPECT : gcrg_pkg::S_NBR_RD;
            end
            gcrg_pkg::S_EXPECT: begin
                n_state = (w_cur != r_exp[w_id_idx]) ? gcrg_pkg::S_DONE
                          : gcrg_pkg::S_TGT_RD;
            end
            gcrg_pkg::S_TGT_RD:   n_state = gcrg_pkg::S_TGT_EVAL;
            gcrg_pkg::S_TGT_EVAL: n_state = gcrg_pkg::S_DONE;
            gcrg_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_state = gcrg_pkg::S_IDLE;
                end
            end
            default: n_state = gcrg_pkg::S_IDLE;
        endcase
    end

    // Datapath controls
    always_comb begin
        n_k         = r_k;
        n_dir       = r_dir;
        n_status    = r_status;
        n_next      = r_next;
        n_out_valid = w_out_fire ? 1'b0 : r_out_valid;
        n_out       = r_out;
        w_wr_en     = 1'b0;
        w_wr_addr   = cell_addr(w_cur);
        w_wr_data   = w_id_own;
        w_rd_en     = 1'b0;
        w_rd_addr   = cell_addr(w_cur);
        w_veh_we    = 1'b0;
        w_veh_prev  = w_cur;
        w_veh_exp   = w_cur;
        w_base      = w_cur;
        w_nib       = 4'h0;
        unique case (r_state)
            gcrg_pkg::S_IDLE: begin
                n_k      = 2'd0;
                n_dir    = gcrg_pkg::DIR_STOP;
                n_status = gcrg_pkg::ST_OK;
            end
            gcrg_pkg::S_CHK_CUR: begin
                if (w_id_bad) begin
                    n_status = gcrg_pkg::ST_BAD_ID;
                end else if (!w_nbr.in_grid) begin
                    n_status = gcrg_pkg::ST_BAD_CURRENT;
                end
            end
            gcrg_pkg::S_PLACE_RD: begin
                w_rd_en = 1'b1;
            end
            gcrg_pkg::S_PLACE_EVAL: begin
                if (w_rd_data != FREE_MARK) begin
                    n_status = gcrg_pkg::ST_START_TAKEN;
                end else begin
                    w_wr_en  = 1'b1;
                    w_veh_we = 1'b1;
                end
            end
            gcrg_pkg::S_CHK_GOAL: begin
                w_base = w_goal;
                if (!w_nbr.in_grid) begin
                    n_status = gcrg_pkg::ST_BAD_GOAL;
                end
            end
            gcrg_pkg::S_NBR_RD: begin
                w_nib     = r_dir_offsets[4*r_k +: 4];
                w_rd_en   = w_nbr.in_grid;
                w_rd_addr = cell_addr(w_nbr.pos);
            end
            gcrg_pkg::S_NBR_EVAL: begin
                // Take the last eligible neighbor toward the goal, else the first one
                w_nib = r_dir_offsets[4*r_k +: 4];
                if (w_nbr.in_grid && w_owner_ok
                    && (r_dir == gcrg_pkg::DIR_STOP || w_nbr.toward)) begin
                    n_dir = {1'b0, r_k};
                end
                n_k = r_k + 2'd1;
            end
            gcrg_pkg::S_EXPECT: begin
                if (w_cur != r_exp[w_id_idx]) begin
                    n_status = gcrg_pkg::ST_UNEXPECTED;
                    n_dir    = gcrg_pkg::DIR_STOP;
                end else if (r_prev[w_id_idx] != w_cur) begin
                    // Release the cell left behind
                    w_wr_en   = 1'b1;
                    w_wr_addr = cell_addr(r_prev[w_id_idx]);
                    w_wr_data = FREE_MARK;
                end
            end
            gcrg_pkg::S_TGT_RD: begin
                w_nib     = (r_dir == gcrg_pkg::DIR_STOP) ? 4'h0
                            : r_dir_offsets[4*r_dir[1:0] +: 4];
                w_rd_en   = 1'b1;
                w_rd_addr = cell_addr(w_nbr.pos);
                n_next    = w_nbr.pos;
            end
            gcrg_pkg::S_TGT_EVAL: begin
                // Cancel to stop when anyone holds the target
                if (w_rd_data != FREE_MARK) begin
                    n_dir = gcrg_pkg::DIR_STOP;
                end
                w_wr_en   = 1'b1;
                w_wr_addr = cell_addr(w_target);
                w_veh_we  = 1'b1;
                w_veh_exp = w_target;
            end
            gcrg_pkg::S_DONE: begin
                if (w_out_free) begin
                    n_out_valid          = 1'b1;
                    n_out.step_direction = r_dir;
                    n_out.status_code    = r_status;
                end
            end
            default: begin
                n_k = r_k;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= gcrg_pkg::S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_in_fire) begin
            r_req <= i_in_data;
        end
        r_k      <= n_k;
        r_dir    <= n_dir;
        r_status <= n_status;
        r_next   <= n_next;
        r_out    <= n_out;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_count     <= gcrg_pkg::RST_ROW_COUNT;
            r_column_count  <= gcrg_pkg::RST_COLUMN_COUNT;
            r_vehicle_count <= gcrg_pkg::RST_VEHICLE_COUNT;
            r_dir_offsets   <= gcrg_pkg::RST_DIR_OFFSETS;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                gcrg_pkg::CFG_ROW_COUNT:     r_row_count     <= i_cfg_data[6:0];
                gcrg_pkg::CFG_COLUMN_COUNT:  r_column_count  <= i_cfg_data[6:0];
                gcrg_pkg::CFG_VEHICLE_COUNT: r_vehicle_count <= i_cfg_data[4:0];
                gcrg_pkg::CFG_DIR_OFFSETS:   r_dir_offsets   <= i_cfg_data;
                default:                     r_dir_offsets   <= r_dir_offsets;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_veh_we) begin
            r_prev[w_id_idx] <= w_veh_prev;
            r_exp[w_id_idx]  <= w_veh_exp;
        end
    end

endmodule

`default_nettype wire

// ===== tb/sv/testbench.sv =====
// Self-checking testbench of the grid cell reservation guide core.
`timescale 1ns / 100ps

module testbench;

    localparam int GRID_ROWS   = gcrg_pkg::DEF_MAX_ROWS;
    localparam int GRID_COLS   = gcrg_pkg::DEF_MAX_COLUMNS;
    localparam int FLEET       = gcrg_pkg::DEF_MAX_VEHICLES;
    localparam logic [4:0] OWNER_FREE = 5'(FLEET);
    localparam int HOLD_CYCLES = 300;

    typedef enum int {RX_FREE, RX_LIGHT, RX_HEAVY, RX_TOGGLE} t_rx_mode;

    class reservation_scoreboard;
        logic [gcrg_pkg::COUNT_W-1:0]   row_count;
        logic [gcrg_pkg::COUNT_W-1:0]   column_count;
        logic [gcrg_pkg::VCOUNT_W-1:0]  vehicle_count;
        logic [gcrg_pkg::OFFSETS_W-1:0] offsets;
        logic [4:0]                     cell_owner [GRID_ROWS*GRID_COLS];
        gcrg_pkg::t_cell                previous_cell [FLEET];
        gcrg_pkg::t_cell                expected_cell [FLEET];
        gcrg_pkg::t_out_item            expected_answers [$];
        int                             answers_seen;
        int                             mismatches;

        function new();
            row_count     = gcrg_pkg::RST_ROW_COUNT;
            column_count  = gcrg_pkg::RST_COLUMN_COUNT;
            vehicle_count = gcrg_pkg::RST_VEHICLE_COUNT;
            offsets       = gcrg_pkg::RST_DIR_OFFSETS;
            foreach (cell_owner[i]) cell_owner[i] = OWNER_FREE;
            foreach (previous_cell[i]) begin
                previous_cell[i] = '0;
                expected_cell[i] = '0;
            end
            answers_seen = 0;
            mismatches   = 0;
        endfunction

        function void set_register(logic [gcrg_pkg::CFG_IDX_W-1:0] idx,
                                   logic [gcrg_pkg::CFG_DATA_W-1:0] data);
            case (idx)
                gcrg_pkg::CFG_ROW_COUNT:     row_count     = data[gcrg_pkg::COUNT_W-1:0];
                gcrg_pkg::CFG_COLUMN_COUNT:  column_count  = data[gcrg_pkg::COUNT_W-1:0];
                gcrg_pkg::CFG_VEHICLE_COUNT: vehicle_count = data[gcrg_pkg::VCOUNT_W-1:0];
                gcrg_pkg::CFG_DIR_OFFSETS:   offsets       = data[gcrg_pkg::OFFSETS_W-1:0];
                default: ;
            endcase
        endfunction

        function int rows_in_use();
            return (int'(row_count) < GRID_ROWS) ? int'(row_count) : GRID_ROWS;
        endfunction

        function int cols_in_use();
            return (int'(column_count) < GRID_COLS) ? int'(column_count) : GRID_COLS;
        endfunction

        function int fleet_in_use();
            return (int'(vehicle_count) < FLEET) ? int'(vehicle_count) : FLEET;
        endfunction

        function bit on_grid(int r, int c);
            return r >= 0 && c >= 0 && r < rows_in_use() && c < cols_in_use();
        endfunction

        function int slot_of(int r, int c);
            return r * GRID_COLS + c;
        endfunction

        function int row_delta(int k);
            logic [3:0] nib;
            nib = offsets[4*k +: 4];
            return int'($signed(nib[1:0]));
        endfunction

        function int col_delta(int k);
            logic [3:0] nib;
            nib = offsets[4*k +: 4];
            return int'($signed(nib[3:2]));
        endfunction

        // Apply one accepted request to the map and queue the answer it must produce.
        function void note_request(gcrg_pkg::t_in_item req);
            int id, cr, cc, gr, gc, dr, dc, k, nr, nc, dir;
            logic [4:0] w;
            logic [gcrg_pkg::STATUS_W-1:0] status;
            gcrg_pkg::t_cell cur;
            gcrg_pkg::t_out_item ans;
            id = req.vehicle_id;
            cr = req.current_row;
            cc = req.current_column;
            gr = req.goal_row;
            gc = req.goal_column;
            cur.row = req.current_row;
            cur.col = req.current_column;
            dir = gcrg_pkg::DIR_STOP;
            status = gcrg_pkg::ST_OK;
            if (id >= fleet_in_use()) begin
                status = gcrg_pkg::ST_BAD_ID;
            end else if (!on_grid(cr, cc)) begin
                status = gcrg_pkg::ST_BAD_CURRENT;
            end else if (req.action == gcrg_pkg::ACT_PLACE) begin
                if (cell_owner[slot_of(cr, cc)] != OWNER_FREE) begin
                    status = gcrg_pkg::ST_START_TAKEN;
                end else begin
                    cell_owner[slot_of(cr, cc)] = 5'(id);
                    previous_cell[id] = cur;
                    expected_cell[id] = cur;
                end
            end else if (!on_grid(gr, gc)) begin
                status = gcrg_pkg::ST_BAD_GOAL;
            end else begin
                dr = gr - cr;
                dc = gc - cc;
                // Keep the last neighbor that points toward the goal, else the first free one
                for (k = 0; k < 4; k++) begin
                    nr = cr + row_delta(k);
                    nc = cc + col_delta(k);
                    if (on_grid(nr, nc)) begin
                        w = cell_owner[slot_of(nr, nc)];
                        if ((w == OWNER_FREE || w == 5'(id)) &&
                            (dir == gcrg_pkg::DIR_STOP ||
                             row_delta(k) * dr + col_delta(k) * dc > 0))
                            dir = k;
                    end
                end
                if (cur != expected_cell[id]) begin
                    status = gcrg_pkg::ST_UNEXPECTED;
                    dir = gcrg_pkg::DIR_STOP;
                end else begin
                    if (previous_cell[id] != cur)
                        cell_owner[slot_of(previous_cell[id].row, previous_cell[id].col)] =
                            OWNER_FREE;
                    nr = cr;
                    nc = cc;
                    if (dir != gcrg_pkg::DIR_STOP) begin
                        nr = cr + row_delta(dir);
                        nc = cc + col_delta(dir);
                    end
                    // Cancel to stop when the target is held by anyone
                    if (cell_owner[slot_of(nr, nc)] != OWNER_FREE) begin
                        dir = gcrg_pkg::DIR_STOP;
                        nr = cr;
                        nc = cc;
                    end
                    previous_cell[id] = cur;
                    expected_cell[id].row = gcrg_pkg::COORD_W'(nr);
                    expected_cell[id].col = gcrg_pkg::COORD_W'(nc);
                    cell_owner[slot_of(nr, nc)] = 5'(id);
                end
            end
            ans.step_direction = gcrg_pkg::DIR_W'(dir);
            ans.status_code = status;
            expected_answers.push_back(ans);
        endfunction

        task report_mismatch(string msg);
            $display("[%0t] mismatch at result %0d: %s", $realtime, answers_seen, msg);
            mismatches++;
        endtask

        task check_answer(gcrg_pkg::t_out_item got);
            gcrg_pkg::t_out_item want;
            if (expected_answers.size() == 0) begin
                report_mismatch($sformatf("unexpected result dir %0d status %0d",
                                          got.step_direction, got.status_code));
            end else begin
                want = expected_answers.pop_front();
                if (got.step_direction !== want.step_direction)
                    report_mismatch($sformatf("step_direction %0d, want %0d",
                                              got.step_direction, want.step_direction));
                if (got.status_code !== want.status_code)
                    report_mismatch($sformatf("status_code %0d, want %0d",
                                              got.status_code, want.status_code));
            end
            answers_seen++;
        endtask
    endclass

    logic i_clk = 1'b0;
    logic i_rst_n;
    logic i_in_valid;
    logic o_in_stall;
    gcrg_pkg::t_in_item i_in_data;
    logic o_out_valid;
    logic i_out_stall;
    gcrg_pkg::t_out_item o_out_data;
    logic i_cfg_we;
    logic [gcrg_pkg::CFG_IDX_W-1:0] i_cfg_index;
    logic [gcrg_pkg::CFG_DATA_W-1:0] i_cfg_data;

    reservation_scoreboard sb;
    int burst_left = 0;
    int hold_request = 0;

    grid_cell_reservation_guide_core dut (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in_valid),
        .o_in_stall  (o_in_stall),
        .i_in_data   (i_in_data),
        .o_out_valid (o_out_valid),
        .i_out_stall (i_out_stall),
        .o_out_data  (o_out_data),
        .i_cfg_we    (i_cfg_we),
        .i_cfg_index (i_cfg_index),
        .i_cfg_data  (i_cfg_data)
    );

    always begin
        #2 i_clk = 1'b1;
        #2 i_clk = 1'b0;
    end

    function automatic gcrg_pkg::t_in_item make_request(logic action, int id, int cr, int cc,
                                                        int gr, int gc);
        gcrg_pkg::t_in_item req;
        req.action         = action;
        req.vehicle_id     = gcrg_pkg::ID_FIELD_W'(id);
        req.current_row    = gcrg_pkg::COORD_W'(cr);
        req.current_column = gcrg_pkg::COORD_W'(cc);
        req.goal_row       = gcrg_pkg::COORD_W'(gr);
        req.goal_column    = gcrg_pkg::COORD_W'(gc);
        return req;
    endfunction

    function automatic gcrg_pkg::t_cell random_cell_on_grid();
        gcrg_pkg::t_cell c;
        c.row = gcrg_pkg::COORD_W'($urandom_range(sb.rows_in_use() - 1));
        c.col = gcrg_pkg::COORD_W'($urandom_range(sb.cols_in_use() - 1));
        return c;
    endfunction

    function automatic gcrg_pkg::t_cell free_cell_on_grid();
        gcrg_pkg::t_cell c;
        int tries;
        c = random_cell_on_grid();
        for (tries = 0; tries < 24; tries++) begin
            if (sb.cell_owner[sb.slot_of(c.row, c.col)] == OWNER_FREE)
                return c;
            c = random_cell_on_grid();
        end
        return c;
    endfunction

    // Mostly well-formed steps along each vehicle's route, some places, some noise.
    function automatic gcrg_pkg::t_in_item random_request();
        int pick, id, tries;
        bit found;
        gcrg_pkg::t_cell cur, goal;
        gcrg_pkg::t_in_item req;
        pick = $urandom_range(99);
        req = gcrg_pkg::t_in_item'($bits(gcrg_pkg::t_in_item)'($urandom));
        if (sb.rows_in_use() == 0 || sb.cols_in_use() == 0 || sb.fleet_in_use() == 0 ||
            pick < 12)
            return req;
        if (pick < 22) begin
            cur = free_cell_on_grid();
            return make_request(gcrg_pkg::ACT_PLACE, $urandom_range(sb.fleet_in_use() - 1),
                                cur.row, cur.col, $urandom_range(63), $urandom_range(63));
        end
        goal = random_cell_on_grid();
        if (pick < 27) begin
            // Break the route: step from some cell that is likely not the expected one
            cur = random_cell_on_grid();
            return make_request(gcrg_pkg::ACT_STEP, $urandom_range(FLEET - 1), cur.row,
                                cur.col, goal.row, goal.col);
        end
        found = 0;
        id = 0;
        for (tries = 0; tries < 8 && !found; tries++) begin
            id = $urandom_range(sb.fleet_in_use() - 1);
            cur = sb.expected_cell[id];
            found = sb.on_grid(cur.row, cur.col);
        end
        if (!found) begin
            cur = free_cell_on_grid();
            return make_request(gcrg_pkg::ACT_PLACE, id, cur.row, cur.col, goal.row,
                                goal.col);
        end
        case ($urandom_range(3))
            0: goal = cur;
            1: begin
                goal.row = gcrg_pkg::COORD_W'($urandom_range(63));
                goal.col = gcrg_pkg::COORD_W'($urandom_range(63));
            end
            default: ;
        endcase
        return make_request(gcrg_pkg::ACT_STEP, id, cur.row, cur.col, goal.row, goal.col);
    endfunction

    task automatic offer_request(gcrg_pkg::t_in_item req);
        int gap;
        if (burst_left == 0) begin
            burst_left = $urandom_range(20, 1);
            gap = ($urandom_range(3) == 0) ? 0 : $urandom_range(15, 1);
            if (gap > 0) begin
                @(negedge i_clk);
                i_in_valid = 1'b0;
                repeat (gap - 1) @(negedge i_clk);
            end
        end
        burst_left--;
        @(negedge i_clk);
        i_in_valid = 1'b1;
        i_in_data = req;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(req);
    endtask

    task automatic write_register(logic [gcrg_pkg::CFG_IDX_W-1:0] idx,
                                  logic [gcrg_pkg::CFG_DATA_W-1:0] data);
        @(negedge i_clk);
        i_cfg_we = 1'b1;
        i_cfg_index = idx;
        i_cfg_data = data;
        @(negedge i_clk);
        i_cfg_we = 1'b0;
        sb.set_register(idx, data);
    endtask

    task automatic wait_idle();
        @(negedge i_clk);
        i_in_valid = 1'b0;
        burst_left = 0;
        while (sb.expected_answers.size() != 0) @(posedge i_clk);
    endtask

    task automatic run_phase(int rows, int cols, int vehicles, int offs, int count,
                             bit squeeze);
        int n, v;
        gcrg_pkg::t_cell spot;
        wait_idle();
        write_register(gcrg_pkg::CFG_ROW_COUNT, gcrg_pkg::CFG_DATA_W'(rows));
        write_register(gcrg_pkg::CFG_COLUMN_COUNT, gcrg_pkg::CFG_DATA_W'(cols));
        write_register(gcrg_pkg::CFG_VEHICLE_COUNT, gcrg_pkg::CFG_DATA_W'(vehicles));
        write_register(gcrg_pkg::CFG_DIR_OFFSETS, gcrg_pkg::CFG_DATA_W'(offs));
        // Bring vehicles back onto the grid in use
        if (sb.rows_in_use() > 0 && sb.cols_in_use() > 0) begin
            for (v = 0; v < sb.fleet_in_use(); v++) begin
                spot = sb.expected_cell[v];
                if (!sb.on_grid(spot.row, spot.col) || $urandom_range(1) == 1) begin
                    spot = free_cell_on_grid();
                    offer_request(make_request(gcrg_pkg::ACT_PLACE, v, spot.row, spot.col,
                                               $urandom_range(63), $urandom_range(63)));
                end
            end
        end
        for (n = 0; n < count; n++) begin
            if (squeeze && n == count / 3)
                hold_request = HOLD_CYCLES;
            offer_request(random_request());
        end
    endtask

    // Result side stall pattern, with an occasional long hold-off
    initial begin
        t_rx_mode mode;
        int mode_left;
        mode = RX_FREE;
        mode_left = 0;
        i_out_stall = 1'b0;
        forever begin
            @(negedge i_clk);
            if (hold_request > 0) begin
                mode_left = hold_request;
                hold_request = 0;
                i_out_stall = 1'b1;
                repeat (mode_left - 1) @(negedge i_clk);
                mode_left = 0;
            end else begin
                if (mode_left == 0) begin
                    mode = t_rx_mode'($urandom_range(3));
                    mode_left = $urandom_range(80, 10);
                end
                mode_left--;
                case (mode)
                    RX_LIGHT:  i_out_stall = ($urandom_range(3) == 0);
                    RX_HEAVY:  i_out_stall = ($urandom_range(3) != 0);
                    RX_TOGGLE: i_out_stall = ~i_out_stall;
                    default:   i_out_stall = 1'b0;
                endcase
            end
        end
    end

    always @(posedge i_clk) begin
        if (i_rst_n === 1'b1 && o_out_valid === 1'b1 && i_out_stall == 1'b0)
            sb.check_answer(o_out_data);
    end

    initial begin
        #(2_000_000);
        $display("testbench NOT OK");
        $finish;
    end

    initial begin
        int k;
        gcrg_pkg::t_cell spot;
        sb = new();
        i_rst_n = 1'b0;
        i_in_valid = 1'b0;
        i_in_data = '0;
        i_cfg_we = 1'b0;
        i_cfg_index = '0;
        i_cfg_data = '0;
        repeat (8) @(negedge i_clk);
        i_rst_n = 1'b1;

        // Place the whole fleet on corners and one row, then exercise steps
        offer_request(make_request(gcrg_pkg::ACT_PLACE, 0, 0, 0, 0, 0));
        offer_request(make_request(gcrg_pkg::ACT_PLACE, 1, 63, 63, 63, 63));
        offer_request(make_request(gcrg_pkg::ACT_PLACE, 2, 0, 63, 0, 0));
        offer_request(make_request(gcrg_pkg::ACT_PLACE, 3, 63, 0, 63, 63));
        for (k = 4; k < FLEET; k++)
            offer_request(make_request(gcrg_pkg::ACT_PLACE, k, 32, 4 * (k - 4), 63, 63));
        offer_request(make_request(gcrg_pkg::ACT_PLACE, 6, 0, 0, 63, 0));
        offer_request(make_request(gcrg_pkg::ACT_STEP, 0, 0, 0, 63, 63));
        offer_request(make_request(gcrg_pkg::ACT_STEP, 1, 0, 0, 63, 63));
        offer_request(make_request(gcrg_pkg::ACT_STEP, 1, 63, 63, 63, 63));
        offer_request(make_request(gcrg_pkg::ACT_STEP, 2, 0, 63, 0, 0));
        offer_request(make_request(gcrg_pkg::ACT_STEP, 3, 63, 0, 0, 63));
        offer_request(make_request(gcrg_pkg::ACT_STEP, 4, 32, 0, 32, 63));
        spot = sb.expected_cell[4];
        offer_request(make_request(gcrg_pkg::ACT_STEP, 4, spot.row, spot.col, 32, 63));

        run_phase(64, 64, 16, gcrg_pkg::RST_DIR_OFFSETS, 200, 1'b1);
        run_phase(8, 8, 16, $urandom, 150, 1'b0);
        run_phase(1, 64, 5, 16'h4C03, 120, 1'b1);
        run_phase(127, 127, 31, 16'hFFFF, 120, 1'b1);
        run_phase(0, 64, 16, gcrg_pkg::RST_DIR_OFFSETS, 30, 1'b0);
        run_phase(64, 64, 0, 16'h0000, 20, 1'b0);
        run_phase(3, 5, 16, $urandom, 150, 1'b0);
        run_phase(64, 1, 12, $urandom, 120, 1'b1);
        repeat (3)
            run_phase($urandom_range(64, 1), $urandom_range(64, 1), $urandom_range(16, 1),
                      $urandom, 130, 1'($urandom_range(1)));

        wait_idle();
        repeat (40) @(posedge i_clk);
        if (sb.mismatches == 0)
            $display("testbench OK");
        else
            $display("testbench NOT OK");
        $finish;
    end

endmodule
